FILE: rtl/core/atmf_pkg.sv
// Shared types and constants of the trimmed-mean converter filter.
package atmf_pkg;

    // Field widths of one sample and one result.
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 13;

    // Upper clamp of the result.
    localparam logic [LEVEL_W-1:0] LEVEL_CEIL = 13'd4096;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

FILE: rtl/core/atmf_ifs.sv
// Valid/ready channel interfaces for samples and results.
interface sample_if;
    import atmf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface level_if;
    import atmf_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

FILE: rtl/core/atmf_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module atmf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/adc_trimmed_mean_filter.sv
// Trimmed-mean filter: samples are accepted one per cycle until a burst of BURST_LEN is held.
// After the last sample of a burst the rank scan runs, then ST_DRAIN, then ST_FINISH loads the result;
// the rank scan reads the burst RAM once per cycle through its single read port.
// No sample is accepted during the scan, ST_DRAIN or ST_FINISH, which waits until the output register is free.
// Reset clears the burst count, the floor register (to 0) and all control state.
module adc_trimmed_mean_filter #(
    parameter int BURST_LEN  = 12,
    parameter int DROP_COUNT = 4,
    parameter int MEAN_SHIFT = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [atmf_pkg::SAMPLE_W-1:0] cfg_data,
    sample_if.sink                        samples,
    level_if.source                       levels
);
    import atmf_pkg::*;

    localparam int IW = $clog2(BURST_LEN);
    localparam int PW = $clog2(BURST_LEN + 1);
    localparam int SW = $clog2(BURST_LEN * ((1 << SAMPLE_W) - 1) + 1);
    localparam int unsigned LO = DROP_COUNT / 2;
    localparam int unsigned HI = (LO < BURST_LEN) ? BURST_LEN - LO : 0;

    state_t              state_reg, state_next;
    logic [SAMPLE_W-1:0] floor_reg;
    logic [IW-1:0]       count_reg, count_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic                pend_valid_reg;
    logic [PW-1:0]       pend_ptr_reg;
    logic [IW-1:0]       pend_idx_reg;
    logic [SAMPLE_W-1:0] key_reg, key_next;
    logic [PW-1:0]       rank_reg, rank_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;

    logic                accept;
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic [SAMPLE_W-1:0] rd_data;
    logic [IW-1:0]       cmp_idx;
    logic                cmp_less;
    logic [PW-1:0]       rank_final;
    logic                keep;
    logic [SW-1:0]       avg;

    assign accept = samples.valid && samples.ready;

    // Burst storage: written by incoming samples, read by the rank scan.
    atmf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BURST_LEN)
    ) u_burst_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (count_reg),
        .wr_data (samples.sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Floor register, written from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= '0;
        end
        else if (cfg_write)
        begin
            floor_reg <= cfg_data;
        end
    end

    // Controller: collect the burst, scan ranks, then publish the result.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        samples.ready  = 1'b0;
        out_valid_next = out_valid_reg && !levels.ready;
        level_next     = level_reg;
        case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    if (count_reg == IW'(BURST_LEN - 1))
                    begin
                        count_next = '0;
                        idx_next   = '0;
                        ptr_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // Pointer zero fetches the key, the others fetch each compared entry.
                rd_en   = 1'b1;
                rd_addr = (ptr_reg == '0) ? idx_reg : IW'(ptr_reg - 1'b1);
                if (ptr_reg == PW'(BURST_LEN))
                begin
                    ptr_next = '0;
                    if (idx_reg == IW'(BURST_LEN - 1))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || levels.ready)
                begin
                    out_valid_next = 1'b1;
                    if (avg <= SW'(floor_reg))
                    begin
                        level_next = LEVEL_W'(floor_reg);
                    end
                    else if (avg >= SW'(LEVEL_CEIL))
                    begin
                        level_next = LEVEL_CEIL;
                    end
                    else
                    begin
                        level_next = LEVEL_W'(avg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Rank accumulation: an entry ranks below the key if smaller, or equal with a lower index.
    assign cmp_idx    = IW'(pend_ptr_reg - 1'b1);
    assign cmp_less   = (rd_data < key_reg) || ((rd_data == key_reg) && (cmp_idx < pend_idx_reg));
    assign rank_final = rank_reg + PW'(cmp_less);
    assign keep       = (32'(rank_final) >= LO) && (32'(rank_final) < HI);
    assign avg        = sum_reg >> MEAN_SHIFT;

    always_comb
    begin
        key_next  = key_reg;
        rank_next = rank_reg;
        sum_next  = sum_reg;
        if (pend_valid_reg)
        begin
            if (pend_ptr_reg == '0)
            begin
                key_next = rd_data;
            end
            else if (pend_ptr_reg == PW'(BURST_LEN))
            begin
                rank_next = '0;
                if (keep)
                begin
                    sum_next = sum_reg + SW'(key_reg);
                end
            end
            else
            begin
                rank_next = rank_final;
            end
        end
        if (state_reg == ST_FINISH && state_next == ST_IDLE)
        begin
            sum_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_ptr_reg   <= '0;
            pend_idx_reg   <= '0;
            rank_reg       <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= rd_en;
            pend_ptr_reg   <= ptr_reg;
            pend_idx_reg   <= idx_reg;
            rank_reg       <= rank_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        level_reg <= level_next;
    end

    assign levels.valid = out_valid_reg;
    assign levels.level = level_reg;

`ifndef SYNTHESIS
    // A published result never exceeds the ceiling.
    a_level_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        levels.valid |-> (levels.level <= LEVEL_CEIL))
        else $error("result above ceiling");

    // The burst write pointer stays inside the RAM.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(BURST_LEN - 1))
        else $error("burst count out of range");

    // The last sample of a burst starts the rank scan.
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && count_reg == IW'(BURST_LEN - 1)) |=> (state_reg == ST_SCAN))
        else $error("rank scan did not start");

    // A partial rank can never reach the burst length.
    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        rank_reg < PW'(BURST_LEN))
        else $error("rank counter overflow");
`endif

endmodule

FILE: bench/atmf_bench_pkg.sv
// Scoreboard class that predicts and checks the trimmed-mean filter results.
package atmf_bench_pkg;
    import atmf_pkg::*;

    // Burst shape of the filter instance under test.
    localparam int BURST_LEN  = 12;
    localparam int DROP_COUNT = 4;
    localparam int MEAN_SHIFT = 3;

    class trimmed_level_board;
        logic [SAMPLE_W-1:0] burst_samples[BURST_LEN];
        int                  burst_fill;
        logic [SAMPLE_W-1:0] floor_level;
        logic [LEVEL_W-1:0]  levels_due[$];
        int                  fails;

        function new();
            burst_fill  = 0;
            floor_level = '0;
            fails       = 0;
        endfunction

        function void set_floor(input logic [SAMPLE_W-1:0] value);
            floor_level = value;
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        // Sort the burst, drop the outer values, average and clamp.
        function logic [LEVEL_W-1:0] trimmed_level();
            logic [SAMPLE_W-1:0] ordered[BURST_LEN];
            logic [SAMPLE_W-1:0] key;
            int                  j;
            int unsigned         total;
            int unsigned         mean;
            for (int i = 0; i < BURST_LEN; i++)
            begin
                ordered[i] = burst_samples[i];
            end
            for (int i = 1; i < BURST_LEN; i++)
            begin
                key = ordered[i];
                j   = i;
                while (j > 0 && ordered[j-1] > key)
                begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = key;
            end
            total = 0;
            for (int i = DROP_COUNT / 2; i < BURST_LEN - DROP_COUNT / 2; i++)
            begin
                total += 32'(ordered[i]);
            end
            mean = total >> MEAN_SHIFT;
            if (mean <= floor_level)
            begin
                mean = 32'(floor_level);
            end
            if (mean >= LEVEL_CEIL)
            begin
                mean = 32'(LEVEL_CEIL);
            end
            return mean[LEVEL_W-1:0];
        endfunction

        // Note one accepted sample transaction; the last of a burst yields a result.
        function void note_sample(input logic [SAMPLE_W-1:0] value);
            burst_samples[burst_fill] = value;
            burst_fill++;
            if (burst_fill == BURST_LEN)
            begin
                burst_fill = 0;
                levels_due.push_back(trimmed_level());
            end
        endfunction

        // Compare one accepted result transaction with the oldest prediction.
        function void check_level(input logic [LEVEL_W-1:0] actual);
            logic [LEVEL_W-1:0] expected;
            if (levels_due.size() == 0)
            begin
                $error("level: no result expected, actual %0d", actual);
                fails++;
            end
            else
            begin
                expected = levels_due.pop_front();
                if (actual !== expected)
                begin
                    $error("level mismatch: expected %0d, actual %0d", expected, actual);
                    fails++;
                end
            end
        endfunction
    endclass

endpackage

FILE: bench/adc_trimmed_mean_filter_tb.sv
// Self-checking testbench of the trimmed-mean converter filter.
module adc_trimmed_mean_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import atmf_pkg::*;
    import atmf_bench_pkg::*;

    // A burst ends with a rank scan, which the quiet wait covers with margin.
    localparam int QUIET_CYCLES    = BURST_LEN * (BURST_LEN + 1) + 2 + 40;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_BURSTS    = 15;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_CLUSTER,
        SHAPE_RAILS,
        SHAPE_FLAT
    } burst_shape_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic                cfg_write;
    logic [SAMPLE_W-1:0] cfg_data;

    int  sample_gap_pct;
    int  result_stall_pct;
    bit  hold_off_req;
    int  cycle_count;

    trimmed_level_board board;

    sample_if samples_ch();
    level_if  levels_ch();

    adc_trimmed_mean_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .samples   (samples_ch),
        .levels    (levels_ch)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("adc_trimmed_mean_filter_tb NOT OK");
            $finish;
        end
    end

    // Watch both channels for accepted transactions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                board.note_sample(samples_ch.sample);
            end
            if (levels_ch.valid && levels_ch.ready)
            begin
                board.check_level(levels_ch.level);
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left       = 0;
        levels_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req    = 1'b0;
                hold_left       = HOLD_OFF_CYCLES;
                levels_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
            end
            else
            begin
                levels_ch.ready <= ($urandom_range(0, 99) >= result_stall_pct);
            end
        end
    end

    // Offer one sample transaction, with random gaps, and wait until it is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(0, 99) < sample_gap_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(negedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= value;
        do
        begin
            @(posedge clk);
        end
        while (!samples_ch.ready);
        @(negedge clk);
    endtask

    // One burst of random content in a random shape.
    task automatic send_random_burst();
        burst_shape_t shape;
        int           center;
        int           spread;
        int           value;
        shape  = burst_shape_t'($urandom_range(0, 3));
        center = $urandom_range(0, 4095);
        spread = $urandom_range(0, 300);
        for (int k = 0; k < BURST_LEN; k++)
        begin
            case (shape)
                SHAPE_CLUSTER:
                begin
                    value = center + $urandom_range(0, 2 * spread) - spread;
                    if (value < 0)
                    begin
                        value = 0;
                    end
                    if (value > 4095)
                    begin
                        value = 4095;
                    end
                end
                SHAPE_RAILS:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        value = $urandom_range(0, 4095);
                    end
                    else
                    begin
                        value = $urandom_range(0, 1) ? 4095 : 0;
                    end
                end
                SHAPE_FLAT:
                begin
                    value = center;
                end
                default:
                begin
                    value = $urandom_range(0, 4095);
                end
            endcase
            send_sample(value[SAMPLE_W-1:0]);
        end
    endtask

    // Write the floor register; only called while the filter is idle.
    task automatic write_floor(input logic [SAMPLE_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        board.set_floor(value);
    endtask

    // Wait for every predicted result, then for the scan to settle.
    task automatic wait_drained();
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // Main sequence: reset, directed bursts, then phases of floor and idling settings.
    initial
    begin
        logic [SAMPLE_W-1:0] phase_floor;
        int                  send_gap[3];
        int                  recv_stall[3];
        int                  mode;
        send_gap   = '{23, 81, 0};
        recv_stall = '{81, 23, 0};
        board            = new();
        cycle_count      = 0;
        hold_off_req     = 1'b0;
        sample_gap_pct   = 0;
        result_stall_pct = 0;
        cfg_write        = 1'b0;
        cfg_data         = '0;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: phase_floor = '0;
                1: phase_floor = SAMPLE_MAX;
                2: phase_floor = 12'd2048;
                4: phase_floor = 12'd1;
                default: phase_floor = SAMPLE_W'($urandom_range(0, 4095));
            endcase
            write_floor(phase_floor);
            mode             = phase / 2;
            sample_gap_pct   = send_gap[mode];
            result_stall_pct = recv_stall[mode];

            // Directed bursts: rails at both ends of the sort, then all samples at full scale.
            if (phase == 0)
            begin
                send_sample(SAMPLE_MAX);
                send_sample('0);
                send_sample(SAMPLE_MAX);
                send_sample('0);
                for (int k = 0; k < BURST_LEN - 4; k++)
                begin
                    send_sample(12'd1 << k);
                end
                for (int k = 0; k < BURST_LEN; k++)
                begin
                    send_sample(SAMPLE_MAX);
                end
            end

            // With no idling, hold results back so the input stalls.
            if (phase == 4)
            begin
                hold_off_req = 1'b1;
            end

            for (int b = 0; b < PHASE_BURSTS; b++)
            begin
                send_random_burst();
            end
            samples_ch.valid <= 1'b0;
            wait_drained();
        end

        if (board.fails == 0 && board.pending() == 0)
        begin
            $display("adc_trimmed_mean_filter_tb OK");
        end
        else
        begin
            $display("adc_trimmed_mean_filter_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: adc_trimmed_mean_filter.f
rtl/core/atmf_pkg.sv
rtl/core/atmf_ifs.sv
rtl/core/atmf_ram.sv
rtl/core/adc_trimmed_mean_filter.sv
bench/atmf_bench_pkg.sv
bench/adc_trimmed_mean_filter_tb.sv
